### hdl/assert_macros.svh
// assertion macros shared by the queue rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define SDEPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SDEPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/sdepq_pkg.sv
// shared types and constants for the sorted double-ended priority queue
// no dependencies
package sdepq_pkg;

    localparam int DATA_W       = 32;
    localparam int CNT_OUT_W    = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        FUNC_INSERT      = 2'd0,
        FUNC_REMOVE_HIGH = 2'd1,
        FUNC_REMOVE_LOW  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef logic [CNT_OUT_W-1:0] t_count;

    // broadcast from the control to every cell
    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

### hdl/sdepq_if.sv
// request and response channels of the queue, valid/ready handshake
// depends on sdepq_pkg
interface sdepq_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      func;
    logic signed [sdepq_pkg::DATA_W-1:0] item_value;
    logic signed [sdepq_pkg::DATA_W-1:0] item_key;

    modport source (output valid, output func, output item_value, output item_key,
                    input ready);
    modport sink   (input valid, input func, input item_value, input item_key,
                    output ready);
endinterface

interface sdepq_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sdepq_pkg::DATA_W-1:0]    highest_value;
    logic signed [sdepq_pkg::DATA_W-1:0]    lowest_value;
    logic [sdepq_pkg::CNT_OUT_W-1:0]        entry_count;
    logic                                   queue_empty;
    logic [1:0]                             status;

    modport source (output valid, output highest_value, output lowest_value,
                    output entry_count, output queue_empty, output status,
                    input ready);
    modport sink   (input valid, input highest_value, input lowest_value,
                    input entry_count, input queue_empty, input status,
                    output ready);
endinterface

### hdl/sdepq_cell.sv
// one slot of the sorted chain: holds a key/value pair, compares against the
// broadcast key and shifts from its neighbors; depends on sdepq_pkg
module sdepq_cell (
    input  logic                           i_clk,
    input  sdepq_pkg::t_cell_ctrl          i_ctrl,
    input  logic                           i_occupied,
    input  logic                           i_prev_open,
    input  logic [sdepq_pkg::DATA_W-1:0]   i_prev_key,
    input  logic [sdepq_pkg::DATA_W-1:0]   i_prev_value,
    input  logic [sdepq_pkg::DATA_W-1:0]   i_next_key,
    input  logic [sdepq_pkg::DATA_W-1:0]   i_next_value,
    output logic                           o_open,
    output logic [sdepq_pkg::DATA_W-1:0]   o_key,
    output logic [sdepq_pkg::DATA_W-1:0]   o_value
);

    logic [sdepq_pkg::DATA_W-1:0] r_key;
    logic [sdepq_pkg::DATA_W-1:0] r_value;
    logic [sdepq_pkg::DATA_W-1:0] n_key;
    logic [sdepq_pkg::DATA_W-1:0] n_value;

    // open: new word belongs at or above this slot
    assign o_open  = !i_occupied || ($signed(r_key) < $signed(i_ctrl.key));
    assign o_key   = r_key;
    assign o_value = r_value;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_ctrl.ins && o_open) begin
            if (i_prev_open) begin
                n_key   = i_prev_key;
                n_value = i_prev_value;
            end else begin
                n_key   = i_ctrl.key;
                n_value = i_ctrl.value;
            end
        end else if (i_ctrl.pop) begin
            n_key   = i_next_key;
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

endmodule

### hdl/sorted_double_ended_priority_queue.sv
// Sorted double-ended priority queue built as a chain of compare/shift cells.
//
// i_req (sink): func 0 inserts (item_value, item_key), 1 removes the entry
// with the highest key, 2 removes the lowest. Equal keys leave the high end
// in arrival order. func 3 does nothing and just reports.
// o_rsp (source): one word per request with the head and tail values after
// the operation (zero when empty), the entry count, an empty flag and a
// status: done, removal from empty queue ignored, insert into full queue
// dropped.
// A request taken at an edge updates every cell and the entry count at that
// edge; the response is registered from the updated row once the output
// register is free. No new request is taken before that response is loaded,
// so the tail is read out of the cell row before the next request changes it.
// A new request is taken while an earlier response still waits on a stalled
// receiver; a second one then waits until that response is taken.
// Reset clears the entry count and the handshake state; cell contents are
// not cleared since nothing past the count is ever read.
// depends on sdepq_pkg, sdepq_if, sdepq_cell, assert_macros.svh
`include "assert_macros.svh"

module sorted_double_ended_priority_queue #(
    parameter int CAPACITY = sdepq_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdepq_req_if.sink     i_req,
    sdepq_rsp_if.source   o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_pend;
    sdepq_pkg::t_status          r_pend_status;
    sdepq_pkg::t_status          w_status;
    logic                        w_acc;
    logic                        w_load;
    sdepq_pkg::t_cell_ctrl       w_ctrl;

    logic                        r_out_valid;
    logic [sdepq_pkg::DATA_W-1:0] r_out_highest;
    logic [sdepq_pkg::DATA_W-1:0] r_out_lowest;
    sdepq_pkg::t_count           r_out_count;
    logic                        r_out_empty;
    sdepq_pkg::t_status          r_out_status;
    logic [sdepq_pkg::DATA_W-1:0] w_tail;

    logic                        w_open  [CAPACITY];
    logic [sdepq_pkg::DATA_W-1:0] w_key   [CAPACITY];
    logic [sdepq_pkg::DATA_W-1:0] w_value [CAPACITY];

    assign i_req.ready = !r_pend;
    assign w_acc       = i_req.valid && !r_pend;
    assign w_load      = r_pend && (!r_out_valid || o_rsp.ready);

    // decode the request
    always_comb begin
        w_ctrl.ins   = 1'b0;
        w_ctrl.pop   = 1'b0;
        w_ctrl.key   = i_req.item_key;
        w_ctrl.value = i_req.item_value;
        w_status     = sdepq_pkg::STATUS_DONE;
        n_count      = r_count;
        case (sdepq_pkg::t_func'(i_req.func))
            sdepq_pkg::FUNC_INSERT: begin
                if (r_count == CW'(CAPACITY)) begin
                    w_status = sdepq_pkg::STATUS_FULL;
                end else begin
                    w_ctrl.ins = w_acc;
                    n_count    = r_count + CW'(1);
                end
            end
            sdepq_pkg::FUNC_REMOVE_HIGH: begin
                if (r_count == '0) begin
                    w_status = sdepq_pkg::STATUS_EMPTY;
                end else begin
                    w_ctrl.pop = w_acc;
                    n_count    = r_count - CW'(1);
                end
            end
            sdepq_pkg::FUNC_REMOVE_LOW: begin
                if (r_count == '0) begin
                    w_status = sdepq_pkg::STATUS_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                         w_prev_open;
            logic [sdepq_pkg::DATA_W-1:0] w_prev_key;
            logic [sdepq_pkg::DATA_W-1:0] w_prev_value;
            logic [sdepq_pkg::DATA_W-1:0] w_next_key;
            logic [sdepq_pkg::DATA_W-1:0] w_next_value;

            if (g == 0) begin : g_head
                assign w_prev_open  = 1'b0;
                assign w_prev_key   = w_key[g];
                assign w_prev_value = w_value[g];
            end else begin : g_mid
                assign w_prev_open  = w_open[g-1];
                assign w_prev_key   = w_key[g-1];
                assign w_prev_value = w_value[g-1];
            end

            // last slot has nothing behind it; it keeps its own word on a pop
            if (g == CAPACITY - 1) begin : g_tail
                assign w_next_key   = w_key[g];
                assign w_next_value = w_value[g];
            end else begin : g_body
                assign w_next_key   = w_key[g+1];
                assign w_next_value = w_value[g+1];
            end

            sdepq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_occupied   (CW'(g) < r_count),
                .i_prev_open  (w_prev_open),
                .i_prev_key   (w_prev_key),
                .i_prev_value (w_prev_value),
                .i_next_key   (w_next_key),
                .i_next_value (w_next_value),
                .o_open       (w_open[g]),
                .o_key        (w_key[g]),
                .o_value      (w_value[g])
            );
        end
    endgenerate

    // tail readout: and-or over the row, selected by the count
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i + 1) == r_count) begin
                w_tail = w_tail | w_value[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count       <= n_count;
                r_pend        <= 1'b1;
                r_pend_status <= w_status;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_out_valid   <= 1'b1;
                r_out_highest <= (r_count == '0) ? '0 : w_value[0];
                r_out_lowest  <= w_tail;
                r_out_count   <= sdepq_pkg::t_count'(r_count);
                r_out_empty   <= (r_count == '0);
                r_out_status  <= r_pend_status;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.highest_value = r_out_highest;
    assign o_rsp.lowest_value  = r_out_lowest;
    assign o_rsp.entry_count   = r_out_count;
    assign o_rsp.queue_empty   = r_out_empty;
    assign o_rsp.status        = r_out_status;

    `SDEPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count above capacity")
    `SDEPQ_ASSERT_NEXT(a_acc_pend, i_clk, i_rst_n, w_acc, r_pend, "accepted request not pending")
    `SDEPQ_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, w_acc && w_status == sdepq_pkg::STATUS_FULL, $stable(r_count), "dropped insert changed count")
    `SDEPQ_ASSERT(a_empty_flag, i_clk, i_rst_n, !r_out_valid || (r_out_empty == (r_out_count == '0)), "empty flag disagrees with count")
    `SDEPQ_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, w_load, r_out_valid && !r_pend, "loaded response not presented")

endmodule
